@@ rtl/ss4_pkg.sv @@
// ss4_pkg: shared constants and types for the four-lane smoothstep block.
// No dependencies.
package ss4_pkg;

    localparam int LANES_DEF     = 4;
    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_LANES     = 4;
    localparam int IN_W          = 32;
    localparam int OUT_W         = 17;
    localparam int DIFF_W        = 34;

    typedef enum logic
    {
        MODE_CUBIC   = 1'b0,
        MODE_QUINTIC = 1'b1
    } curve_mode_t;

endpackage

@@ rtl/ss4_lane.sv @@
// ss4_lane: one lane. Restoring divider unrolled one quotient bit per stage,
// then a registered polynomial pipeline. Depends on ss4_pkg.
module ss4_lane #(
    parameter int FRAC_BITS = ss4_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic signed [ss4_pkg::IN_W-1:0] v,
    input  logic signed [ss4_pkg::IN_W-1:0] lo,
    input  logic signed [ss4_pkg::IN_W-1:0] hi,
    input  logic                          mode,
    output logic                          out_valid,
    output logic [ss4_pkg::OUT_W-1:0]     r,
    output logic                          degen
);
    import ss4_pkg::*;

    localparam int DS   = FRAC_BITS;     // divider stages
    localparam int NS   = DS + 6;        // total stages after stage 0
    localparam int TW   = FRAC_BITS + 1; // t width
    localparam int MW   = DIFF_W - 1;    // magnitude width
    localparam int PW   = 2 * TW + 4;
    localparam logic [TW-1:0] ONE = TW'(1) << FRAC_BITS;

    typedef struct packed {
        logic          spec;   // t already decided
        logic [TW-1:0] t;
        logic [MW:0]   rem;
        logic [MW-1:0] den;
        logic          degen;
        logic          mode;
    } dv_t;

    // stage 0: differences and special cases
    logic signed [DIFF_W-1:0] num_s, den_s;
    logic [MW-1:0] num_m, den_m;
    dv_t s0;
    always_comb
    begin
        num_s = DIFF_W'(v) - DIFF_W'(lo);
        den_s = DIFF_W'(hi) - DIFF_W'(lo);
        if (den_s[DIFF_W-1])
        begin
            num_s = -num_s;
            den_s = -den_s;
        end
        num_m = num_s[MW-1:0];
        den_m = den_s[MW-1:0];
        s0 = '0;
        s0.den = den_m;
        s0.rem = {1'b0, num_m};
        s0.mode = mode;
        if (den_s == '0)
        begin
            s0.degen = 1'b1;
            s0.spec = 1'b1;
            s0.t = (v < lo) ? '0 : ONE;
        end
        else if (num_s[DIFF_W-1] || num_s == '0)
        begin
            s0.spec = 1'b1;
        end
        else if (num_m >= den_m)
        begin
            s0.spec = 1'b1;
            s0.t = ONE;
        end
    end

    dv_t dv_reg [DS+1];
    logic [NS:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-1:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dv_reg[0] <= s0;
    end

    // divider: one quotient bit per stage, rem < den kept
    for (genvar k = 0; k < DS; k++) begin : g_div
        dv_t d_next;
        logic [MW:0] sh;
        always_comb
        begin
            d_next = dv_reg[k];
            sh = {dv_reg[k].rem[MW-1:0], 1'b0};
            if (!dv_reg[k].spec)
            begin
                if (sh >= {1'b0, dv_reg[k].den})
                begin
                    d_next.rem = sh - {1'b0, dv_reg[k].den};
                    d_next.t = {dv_reg[k].t[TW-2:0], 1'b1};
                end
                else
                begin
                    d_next.rem = sh;
                    d_next.t = {dv_reg[k].t[TW-2:0], 1'b0};
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
                dv_reg[k+1] <= d_next;
        end
    end

    // polynomial pipeline
    logic [TW-1:0] ta_reg, tb_reg, tc_reg;
    logic [TW-1:0] t2b_reg, t2d_reg, t3d_reg;
    logic [TW+2:0] pd_reg;
    logic          md_reg[4];
    logic          dg_reg[6];
    logic [PW-1:0] sq_reg, fin_reg;
    logic [OUT_W-1:0] r_reg;

    logic [PW-1:0] sq_w, t3_w, fin_w;
    logic [TW+5:0] pos_w, neg_w;
    logic [TW+2:0] p_next;
    logic [PW-1:0] rr;

    always_comb
    begin
        sq_w = PW'(ta_reg) * PW'(ta_reg);
        t3_w = PW'(t2b_reg) * PW'(tc_reg);
        pos_w = (TW+6)'(10) * (TW+6)'(ONE) + (TW+6)'(6) * (TW+6)'(t2b_reg);
        neg_w = (TW+6)'(15) * (TW+6)'(tc_reg);
        if (md_reg[2] == MODE_CUBIC)
            p_next = (TW+3)'((TW+6)'(3) * (TW+6)'(ONE) - (TW+6)'(2) * (TW+6)'(tc_reg));
        else
            p_next = (pos_w > neg_w) ? (TW+3)'(pos_w - neg_w) : '0;
        fin_w = (md_reg[3] == MODE_CUBIC) ? PW'(t2d_reg) * PW'(pd_reg)
                                          : PW'(t3d_reg) * PW'(pd_reg);
        rr = fin_reg >> FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ta_reg  <= dv_reg[DS].t;
            md_reg[0] <= dv_reg[DS].mode;
            dg_reg[0] <= dv_reg[DS].degen;
            sq_reg  <= sq_w;
            tb_reg  <= ta_reg;
            t2b_reg <= TW'(sq_reg >> FRAC_BITS);
            tc_reg  <= tb_reg;
            pd_reg  <= p_next;
            t2d_reg <= t2b_reg;
            t3d_reg <= TW'(t3_w >> FRAC_BITS);
            fin_reg <= fin_w;
            r_reg   <= (rr > PW'(ONE)) ? OUT_W'(ONE) : OUT_W'(rr);
            for (int i = 1; i < 4; i++)
                md_reg[i] <= md_reg[i-1];
            for (int i = 1; i < 6; i++)
                dg_reg[i] <= dg_reg[i-1];
        end
    end

    // stage map after divider: ta, sq, (t2b,tc), (pd,t3d,t2d), fin, r

    assign out_valid = vld_reg[NS];
    assign r         = r_reg;
    assign degen     = dg_reg[5];

`ifndef NO_ASSERTIONS
    a_t_range: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[DS+1] |-> ta_reg <= ONE)
        else $error("t above one");
    a_r_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> r <= OUT_W'(ONE))
        else $error("result above one");
    a_degen_t: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_reg[DS] && dv_reg[DS].degen) |-> dv_reg[DS].spec)
        else $error("degenerate lane went through divider");
`endif

endmodule

@@ rtl/smoothstep_four_lane.sv @@
// smoothstep_four_lane: top level, four lanes of smoothstep/smootherstep.
// Depends on ss4_pkg and ss4_lane.
//
// Channel | Signals                                     | Direction
// --------+---------------------------------------------+----------
// in      | in_valid/in_ready, v_*, lo_*, hi_*          | sink
// out     | out_valid/out_ready, r_*, degenerate_mask   | source
// cfg     | cfg_valid/cfg_ready, cfg_data               | sink
//
// One beat per cycle sustained while the output is taken. The pipe is one stage
// for differences, FRAC_BITS divider stages (one quotient bit each), five
// polynomial stages, then the output register. The whole pipe stalls as
// one when the output register is full and not taken (global enable).
// Reset clears valid bits and curve_mode.
module smoothstep_four_lane #(
    parameter int LANES     = ss4_pkg::LANES_DEF,
    parameter int FRAC_BITS = ss4_pkg::FRAC_BITS_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic signed [ss4_pkg::IN_W-1:0] v_x, v_y, v_z, v_w,
    input  logic signed [ss4_pkg::IN_W-1:0] lo_x, lo_y, lo_z, lo_w,
    input  logic signed [ss4_pkg::IN_W-1:0] hi_x, hi_y, hi_z, hi_w,
    output logic out_valid,
    input  logic out_ready,
    output logic [ss4_pkg::OUT_W-1:0] r_x, r_y, r_z, r_w,
    output logic [ss4_pkg::MAX_LANES-1:0] degenerate_mask,
    input  logic cfg_valid,
    output logic cfg_ready,
    input  logic cfg_data
);
    import ss4_pkg::*;

    logic mode_reg;
    logic adv;
    logic signed [IN_W-1:0] v_a [MAX_LANES], lo_a [MAX_LANES], hi_a [MAX_LANES];
    logic [OUT_W-1:0] r_a [MAX_LANES];
    logic [MAX_LANES-1:0] dg_a, vl_a;

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_CUBIC;
        else if (cfg_valid)
            mode_reg <= cfg_data;
    end

    // pipe advances unless a finished beat sits unclaimed at the output
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    assign v_a  = '{v_x, v_y, v_z, v_w};
    assign lo_a = '{lo_x, lo_y, lo_z, lo_w};
    assign hi_a = '{hi_x, hi_y, hi_z, hi_w};

    for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
        if (i < LANES) begin : g_on
            ss4_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
                .clk(clk), .rst_n(rst_n), .adv(adv),
                .in_valid(in_valid && in_ready),
                .v(v_a[i]), .lo(lo_a[i]), .hi(hi_a[i]), .mode(mode_reg),
                .out_valid(vl_a[i]), .r(r_a[i]), .degen(dg_a[i])
            );
        end else begin : g_off
            assign vl_a[i] = 1'b0;
            assign r_a[i]  = '0;
            assign dg_a[i] = 1'b0;
        end
    end

    assign out_valid = vl_a[0];
    assign r_x = r_a[0];
    assign r_y = r_a[1];
    assign r_z = r_a[2];
    assign r_w = r_a[3];
    assign degenerate_mask = dg_a;

`ifndef NO_ASSERTIONS
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid && $stable(r_x))
        else $error("output beat lost under stall");
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");
    a_lanes: assert property (@(posedge clk) disable iff (!rst_n)
        (LANES < 4) |-> r_w == '0)
        else $error("unused lane driven");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// tb_top: self-checking bench for smoothstep_four_lane (cubic and quintic curves).
// Depends on ss4_pkg and the smoothstep_four_lane RTL; needs no other file.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import ss4_pkg::*;

    localparam int ONE_Q = 1 << FRAC_BITS_DEF;
    // pipe depth from the block header: differences, divider, polynomial, output
    localparam int PIPE_LAT = FRAC_BITS_DEF + 7;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [OUT_W-1:0] rx, ry, rz, rw;
        logic [3:0]       mask;
    } shade_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [IN_W-1:0] v_x = '0, v_y = '0, v_z = '0, v_w = '0;
    logic signed [IN_W-1:0] lo_x = '0, lo_y = '0, lo_z = '0, lo_w = '0;
    logic signed [IN_W-1:0] hi_x = '0, hi_y = '0, hi_z = '0, hi_w = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [OUT_W-1:0] r_x, r_y, r_z, r_w;
    logic [MAX_LANES-1:0] degenerate_mask;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic cfg_data = 1'b0;

    smoothstep_four_lane u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .v_x(v_x), .v_y(v_y), .v_z(v_z), .v_w(v_w),
        .lo_x(lo_x), .lo_y(lo_y), .lo_z(lo_z), .lo_w(lo_w),
        .hi_x(hi_x), .hi_y(hi_y), .hi_z(hi_z), .hi_w(hi_w),
        .out_valid(out_valid), .out_ready(out_ready),
        .r_x(r_x), .r_y(r_y), .r_z(r_z), .r_w(r_w),
        .degenerate_mask(degenerate_mask),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // bench copy of the mode register
    curve_mode_t mode_shadow = MODE_CUBIC;
    shade_t      shade_q[$];
    int          mismatches = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_cycles = 0;

    // ---- prediction ----------------------------------------------------

    // clamped ratio t = (v-lo)/(hi-lo) in Q1.16, 0..ONE inclusive
    function automatic logic [63:0] ramp_pos(input logic signed [IN_W-1:0] v,
        input logic signed [IN_W-1:0] lo, input logic signed [IN_W-1:0] hi,
        output logic degen);
        logic signed [63:0] num, den;
        num = 64'(v) - 64'(lo);
        den = 64'(hi) - 64'(lo);
        degen = 1'b0;
        if (den == 0)
        begin
            degen = 1'b1;
            return (v < lo) ? 64'd0 : 64'(ONE_Q);
        end
        if (den < 0)
        begin
            num = -num;
            den = -den;
        end
        if (num <= 0)
            return 64'd0;
        if (num >= den)
            return 64'(ONE_Q);
        return (64'(num) << FRAC_BITS_DEF) / 64'(den);
    endfunction

    function automatic logic [OUT_W-1:0] ease(input logic [63:0] t,
        input curve_mode_t mode);
        logic [63:0] t2, t3, pos, neg, r;
        t2 = (t * t) >> FRAC_BITS_DEF;
        if (mode == MODE_CUBIC)
            r = (t2 * (3 * 64'(ONE_Q) - 2 * t)) >> FRAC_BITS_DEF;
        else
        begin
            t3 = (t2 * t) >> FRAC_BITS_DEF;
            pos = 10 * 64'(ONE_Q) + 6 * t2;
            neg = 15 * t;
            r = (t3 * ((pos > neg) ? pos - neg : 64'd0)) >> FRAC_BITS_DEF;
        end
        if (r > ONE_Q)
            r = ONE_Q;
        return r[OUT_W-1:0];
    endfunction

    function automatic shade_t shade_vec(input logic signed [IN_W-1:0] vv[4],
        input logic signed [IN_W-1:0] ll[4], input logic signed [IN_W-1:0] hh[4]);
        shade_t s;
        logic [OUT_W-1:0] r[4];
        logic d;
        s.mask = '0;
        for (int i = 0; i < 4; i++)
        begin
            r[i] = ease(ramp_pos(vv[i], ll[i], hh[i], d), mode_shadow);
            s.mask[i] = d;
        end
        s.rx = r[0]; s.ry = r[1]; s.rz = r[2]; s.rw = r[3];
        return s;
    endfunction

    // ---- driving -------------------------------------------------------

    // one vector beat; expectation is queued at acceptance.
    // valid stays up into the next beat unless an idle gap is drawn.
    task automatic send_vec(input logic signed [IN_W-1:0] vv[4],
        input logic signed [IN_W-1:0] ll[4], input logic signed [IN_W-1:0] hh[4]);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        v_x <= vv[0]; v_y <= vv[1]; v_z <= vv[2]; v_w <= vv[3];
        lo_x <= ll[0]; lo_y <= ll[1]; lo_z <= ll[2]; lo_w <= ll[3];
        hi_x <= hh[0]; hi_y <= hh[1]; hi_z <= hh[2]; hi_w <= hh[3];
        do
            @(posedge clk);
        while (!in_ready);
        shade_q.push_back(shade_vec(vv, ll, hh));
    endtask

    // register write, only with the pipe drained
    task automatic set_mode(input curve_mode_t mode);
        wait_drain();
        cfg_valid <= 1'b1;
        cfg_data <= mode;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        mode_shadow = mode;
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (shade_q.size() != 0)
            @(posedge clk);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    // random edge value: mostly moderate, sometimes full range
    function automatic logic signed [IN_W-1:0] rnd_word();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(8 * ONE_Q)) - 4 * ONE_Q;
            default: return $signed($urandom_range(2 * ONE_Q)) - ONE_Q;
        endcase
    endfunction

    // well-formed lane mostly (lo<hi, v around the span), sometimes equal edges, else noise
    task automatic rnd_lane(output logic signed [IN_W-1:0] v,
        output logic signed [IN_W-1:0] lo, output logic signed [IN_W-1:0] hi);
        int kind;
        kind = $urandom_range(9);
        lo = rnd_word();
        if (kind < 6)
        begin
            hi = lo + $signed($urandom_range(1, 4 * ONE_Q));
            if (hi < lo)
                hi = lo + 1;
            v = lo - $signed(ONE_Q / 8) + $signed($urandom_range(5 * ONE_Q));
        end
        else if (kind == 6)
        begin
            hi = lo;
            v = lo + $signed($urandom_range(2)) - 1;
        end
        else
        begin
            hi = rnd_word();
            v = rnd_word();
        end
    endtask

    task automatic send_random(input int n);
        logic signed [IN_W-1:0] vv[4], ll[4], hh[4];
        for (int k = 0; k < n; k++)
        begin
            for (int i = 0; i < 4; i++)
                rnd_lane(vv[i], ll[i], hh[i]);
            send_vec(vv, ll, hh);
        end
    endtask

    // ---- tests ---------------------------------------------------------

    // field extremes, equal edges, reversed edges, clamps, both curves
    task automatic test_directed();
        logic signed [IN_W-1:0] mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        for (int m = 0; m < 2; m++)
        begin
            set_mode(m ? MODE_QUINTIC : MODE_CUBIC);
            send_vec('{mn, mx, 0, -1}, '{mn, mn, 0, 0}, '{mx, mx, 0, 0});
            send_vec('{mx, mn, 1, -1}, '{mn, mx, mn, mx}, '{mx, mn, mx, mn});
            send_vec('{ONE_Q/2, ONE_Q/4, 3, ONE_Q-1}, '{0, 0, 0, 0},
                     '{ONE_Q, ONE_Q, ONE_Q, ONE_Q});
            // reversed edges: hi < lo
            send_vec('{ONE_Q/2, 2*ONE_Q, -5, ONE_Q/3}, '{ONE_Q, ONE_Q, ONE_Q, ONE_Q},
                     '{0, 0, 0, 0});
            // v below/above the span, then equal edges at v<lo and v==lo
            send_vec('{-7, 9*ONE_Q, ONE_Q-1, ONE_Q}, '{0, 0, ONE_Q, ONE_Q},
                     '{ONE_Q, ONE_Q, ONE_Q, ONE_Q});
            send_vec('{mn, mx, 32'h55555555, 32'haaaaaaaa}, '{mx, mn, 32'haaaaaaaa,
                     32'h55555555}, '{mx, mn, 32'h55555555, 32'haaaaaaaa});
            send_vec('{1, 0, mx, mn}, '{0, 1, mx-1, mn+1}, '{2, 2, mx, mn});
        end
    endtask

    task automatic test_random_phases();
        int idle[4] = '{0, 58, 0, 23};
        int stall[4] = '{0, 0, 58, 23};
        for (int p = 0; p < 4; p++)
        begin
            set_mode(p % 2 ? MODE_QUINTIC : MODE_CUBIC);
            send_idle_pct = idle[p];
            recv_stall_pct = stall[p];
            send_random(140);
        end
    endtask

    // long output hold-off so the pipe fills and in_ready drops
    task automatic test_backpressure();
        set_mode(MODE_CUBIC);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 200;
        send_random(100);
        hold_cycles = 0;
        set_mode(MODE_QUINTIC);
        send_random(20);
    endtask

    // ---- result side ---------------------------------------------------

    always @(posedge clk)
    begin
        if (hold_cycles > 0)
        begin
            hold_cycles <= hold_cycles - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        shade_t got, exp_s;
        cycle_cnt <= cycle_cnt + 1;
        if (rst_n && out_valid && out_ready)
        begin
            got = '{r_x, r_y, r_z, r_w, degenerate_mask};
            if (shade_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: got %h", got);
            end
            else
            begin
                exp_s = shade_q.pop_front();
                if (got !== exp_s)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp r=%h %h %h %h m=%h got r=%h %h %h %h m=%h",
                                 exp_s.rx, exp_s.ry, exp_s.rz, exp_s.rw, exp_s.mask,
                                 got.rx, got.ry, got.rz, got.rw, got.mask);
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_phases();
        test_backpressure();
        wait_drain();
        if (mismatches == 0 && shade_q.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/ss4_pkg.sv
rtl/ss4_lane.sv
rtl/smoothstep_four_lane.sv
tb/sv/tb_top.sv
